@@ rtl/mtg_pkg.sv @@
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared types, constants and word functions of the MT19937 generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int INDEX_W      = $clog2(STATE_WORDS);

  localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [31:0] SEED_MULT    = 32'd1812433253;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

  localparam logic CMD_SEED = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_MUL
  } state_t;

  typedef struct packed {
    word_t       word;
    logic [31:0] limit;
  } draw_t;

  function automatic word_t twist_word(word_t hi_src, word_t lo_src, word_t far);
    word_t y;
    word_t r;
    y = (hi_src & HIGH_BIT) | (lo_src & LOW_BITS);
    r = far ^ (y >> 1);
    if (y[0]) begin
      r = r ^ TWIST_MATRIX;
    end
    return r;
  endfunction

  function automatic word_t temper(word_t x);
    word_t y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic word_t seed_step(word_t p, logic [INDEX_W-1:0] idx);
    word_t x;
    word_t prod;
    x = p ^ (p >> 30);
    prod = SEED_MULT * x;
    return prod + {{(32-INDEX_W){1'b0}}, idx};
  endfunction

endpackage

@@ rtl/mtg_cell.sv @@
// ----------------------------------------------------------------------------
// mtg_cell
// One state word of the generator chain; takes its neighbor's word on shift.
// ----------------------------------------------------------------------------
module mtg_cell
  import mtg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  word_t d,
  output word_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

@@ rtl/mtg_bound.sv @@
// ----------------------------------------------------------------------------
// mtg_bound
// Output stage: scales the tempered word by the limit and holds the result
// until the transfer completes.
// ----------------------------------------------------------------------------
module mtg_bound
  import mtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  draw_t       draw,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output word_t       random_word,
  output logic [30:0] bounded_value
);

  logic        limit_pos;
  logic [63:0] product;

  assign limit_pos = !draw.limit[31] && (draw.limit != 32'd0);
  assign product   = {32'd0, draw.word} * {32'd0, draw.limit};
  assign free      = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      random_word   <= draw.word;
      bounded_value <= limit_pos ? product[62:32] : 31'd0;
    end
  end

endmodule

@@ rtl/mersenne_twister_generator_core.sv @@
// ----------------------------------------------------------------------------
// mersenne_twister_generator_core
// MT19937 generator built as a rotating chain of 624 word cells.
// ----------------------------------------------------------------------------
// Draw: twist/temper result registered in draw_q, then the scaling multiply
//   loads the result register when the output is free; input waits till then.
// Seed: 624 words: the seed, then one word a cycle from the fill multiplier.
// Reset: synchronous; zeroes every cell at once, no clearing pass.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_core
  import mtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] seed_value,
  input  logic signed [31:0] range_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] random_word,
  output logic [30:0] bounded_value
);

  state_t              state;
  state_t              state_next;
  logic [INDEX_W-1:0]  seed_cnt;
  logic [INDEX_W-1:0]  seed_cnt_next;
  draw_t               draw_q;
  word_t               cells [STATE_WORDS];
  word_t               tail_in;
  word_t               twisted;
  logic                shift;
  logic                load;
  logic                free;
  logic                take;

  assign take    = in_valid && in_ready;
  assign twisted = twist_word(cells[0], cells[1], cells[TWIST_OFFSET]);

  for (genvar k = 0; k < STATE_WORDS; k++) begin : g_chain
    word_t d;
    if (k == STATE_WORDS - 1) begin : g_tail
      assign d = tail_in;
    end else begin : g_body
      assign d = cells[k+1];
    end
    mtg_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (d),
      .q     (cells[k])
    );
  end

  always_comb begin
    state_next    = state;
    seed_cnt_next = seed_cnt;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if (command == CMD_SEED) begin
            state_next    = ST_SEED;
            seed_cnt_next = INDEX_W'(1);
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_SEED: begin
        seed_cnt_next = seed_cnt + INDEX_W'(1);
        if (seed_cnt == INDEX_W'(STATE_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL: begin
        if (free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    shift    = 1'b0;
    load     = 1'b0;
    tail_in  = twisted;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        shift    = take;
        tail_in  = (command == CMD_SEED) ? seed_value : twisted;
      end
      ST_SEED: begin
        shift   = 1'b1;
        tail_in = seed_step(cells[STATE_WORDS-1], seed_cnt);
      end
      ST_MUL: begin
        load = free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      seed_cnt <= '0;
    end else begin
      state    <= state_next;
      seed_cnt <= seed_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && take && command == CMD_DRAW) begin
      draw_q.word  <= temper(twisted);
      draw_q.limit <= range_limit;
    end
  end

  mtg_bound u_bound (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .draw          (draw_q),
    .free          (free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .random_word   (random_word),
    .bounded_value (bounded_value)
  );

`ifndef SYNTHESIS
  a_seed_start: assert property (@(posedge clk) disable iff (rst)
    take && command == CMD_SEED |=> state == ST_SEED && seed_cnt == INDEX_W'(1))
    else $error("seed transfer did not start the fill");

  a_seed_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEED |-> seed_cnt != '0 && seed_cnt < INDEX_W'(STATE_WORDS))
    else $error("fill counter out of range");

  a_draw_mul: assert property (@(posedge clk) disable iff (rst)
    take && command == CMD_DRAW |=> state == ST_MUL)
    else $error("draw transfer did not reach the multiply step");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule

@@ verif/mtg_draw_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_draw_checker
// Watches both channels of the MT19937 core, keeps its own copy of the
// 624-word table and read position, predicts each draw and compares every
// output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module mtg_draw_checker
  import mtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        command,
  input  logic [31:0] seed_value,
  input  logic [31:0] range_limit,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] random_word,
  input  logic [30:0] bounded_value,
  output int          fail_count,
  output int          pending_draws,
  output int          seeds_taken,
  output int          draws_taken,
  output int          results_checked
);

  localparam int          MT_N         = 624;
  localparam int          MT_M         = 397;
  localparam logic [31:0] MT_MATRIX_A  = 32'h9908_b0df;
  localparam logic [31:0] MT_FILL_MULT = 32'd1812433253;
  localparam logic [31:0] MT_MASK_B    = 32'h9d2c_5680;
  localparam logic [31:0] MT_MASK_C    = 32'hefc6_0000;

  typedef struct {
    word_t       word;
    logic [30:0] bounded;
  } draw_result_t;

  word_t        mt_words [MT_N];
  int unsigned  mt_pos;
  draw_result_t expected_draws [$];
  draw_result_t oldest_draw;

  function automatic word_t tempered(word_t raw);
    word_t t;
    t = raw ^ {11'b0, raw[31:11]};
    t = t ^ ({t[24:0], 7'b0} & MT_MASK_B);
    t = t ^ ({t[16:0], 15'b0} & MT_MASK_C);
    t = t ^ {18'b0, t[31:18]};
    return t;
  endfunction

  function automatic void reseed_table(word_t s);
    int i;
    mt_words[0] = s;
    for (i = 1; i < MT_N; i++) begin
      mt_words[i] = MT_FILL_MULT * (mt_words[i-1] ^ {30'b0, mt_words[i-1][31:30]}) + i;
    end
    mt_pos = MT_N;
  endfunction

  function automatic void twist_table();
    int    i;
    word_t y;
    word_t r;
    for (i = 0; i < MT_N; i++) begin
      y = {mt_words[i][31], mt_words[(i + 1) % MT_N][30:0]};
      r = mt_words[(i + MT_M) % MT_N] ^ {1'b0, y[31:1]};
      if (y[0]) begin
        r = r ^ MT_MATRIX_A;
      end
      mt_words[i] = r;
    end
    mt_pos = 0;
  endfunction

  function automatic draw_result_t next_draw(logic [31:0] limit);
    draw_result_t res;
    logic [63:0]  prod;
    if (mt_pos >= MT_N) begin
      twist_table();
    end
    res.word = tempered(mt_words[mt_pos]);
    mt_pos = (mt_pos + 1) & 32'h3ff;
    if (!limit[31] && limit != 32'd0) begin
      prod = {32'b0, res.word} * {32'b0, limit};
      res.bounded = prod[62:32];
    end else begin
      res.bounded = '0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("[%0t] MISMATCH result %0d %s: expected %h got %h",
             $time, results_checked, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mt_words = '{default: '0};
      mt_pos = MT_N + 1;
      expected_draws.delete();
      fail_count = 0;
      pending_draws = 0;
      seeds_taken = 0;
      draws_taken = 0;
      results_checked = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (command == CMD_SEED) begin
          reseed_table(seed_value);
          seeds_taken++;
        end else begin
          expected_draws.push_back(next_draw(range_limit));
          draws_taken++;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_draws.size() == 0) begin
          report_mismatch("with no draw pending", '0, random_word);
        end else begin
          oldest_draw = expected_draws.pop_front();
          if (random_word !== oldest_draw.word) begin
            report_mismatch("random_word", oldest_draw.word, random_word);
          end
          if (bounded_value !== oldest_draw.bounded) begin
            report_mismatch("bounded_value", {1'b0, oldest_draw.bounded},
                            {1'b0, bounded_value});
          end
          results_checked++;
        end
      end
      pending_draws = expected_draws.size();
    end
  end

endmodule

@@ verif/mersenne_twister_generator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mersenne_twister_generator_core_tb
// Drives seed and draw commands into the MT19937 core: a directed opening
// (draws before any seed, limit extremes, back-to-back seeds), then a long
// draw run across the table twist and a random seed/draw mix, with bursty
// input, rotating output stall modes and one long output hold-off.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_core_tb;
  import mtg_pkg::*;

  localparam int RANDOM_ITEMS   = 1330;
  localparam int LONG_RUN       = 700;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 150;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [31:0] seed_value;
  logic [31:0] range_limit;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] random_word;
  logic [30:0] bounded_value;

  int fail_count;
  int pending_draws;
  int seeds_taken;
  int draws_taken;
  int results_checked;

  int burst_left;
  int items_sent;
  int idle_cycles;
  bit hold_done;

  mersenne_twister_generator_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .seed_value    (seed_value),
    .range_limit   (range_limit),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .random_word   (random_word),
    .bounded_value (bounded_value)
  );

  mtg_draw_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .seed_value      (seed_value),
    .range_limit     (range_limit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .random_word     (random_word),
    .bounded_value   (bounded_value),
    .fail_count      (fail_count),
    .pending_draws   (pending_draws),
    .seeds_taken     (seeds_taken),
    .draws_taken     (draws_taken),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] pick_limit();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return {1'b1, r[30:0]};
      2: return 32'h7fff_ffff;
      3: return 32'd1;
      4: return $urandom_range(2, 16);
      5: return 32'h8000_0000;
      default: return r;
    endcase
  endfunction

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 15);
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue(input logic cmd, input logic [31:0] sv, input logic [31:0] rl);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) begin
        command     <= 1'($urandom_range(0, 1));
        seed_value  <= $urandom;
        range_limit <= $urandom;
        @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 20);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    seed_value  <= sv;
    range_limit <= rl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic draw(input logic [31:0] rl);
    issue(CMD_DRAW, $urandom, rl);
  endtask

  task automatic seed(input logic [31:0] sv);
    issue(CMD_SEED, sv, $urandom);
  endtask

  // receiver: rotating stall modes, plus one long hold-off once results flow
  initial begin
    int mode;
    int span;
    int k;
    out_ready <= 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && results_checked >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (k = 0; k < span; k++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ((k % 5) >= 2);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[%0t] watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int n;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    command     <= CMD_DRAW;
    seed_value  <= '0;
    range_limit <= '0;
    burst_left = 0;
    items_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // unseeded table: twist of all zeros gives zeros
    draw(32'd100);
    draw(32'hffff_ffff);
    issue(CMD_DRAW, 32'hffff_ffff, 32'h7fff_ffff);
    issue(CMD_SEED, 32'd5489, 32'hdead_beef);
    draw(32'h7fff_ffff);
    draw(32'd1);
    draw(32'd0);
    draw(32'h8000_0000);
    draw(32'hffff_ffff);
    draw(32'd2);
    seed(32'd0);
    draw(32'd1000);
    draw(32'h4000_0000);
    seed(32'hffff_ffff);
    seed(32'h1234_5678);
    draw(32'h7fff_ffff);
    draw($urandom);
    draw(32'd6);

    // long run past the end of the table, then a mix
    seed(pick_seed());
    for (n = 1; n < RANDOM_ITEMS; n++) begin
      if (n > LONG_RUN && $urandom_range(0, 24) == 0) begin
        seed(pick_seed());
      end else begin
        draw(pick_limit());
      end
    end
    in_valid <= 1'b0;

    // let the checker record the last input transfer before polling
    #1;
    wait (pending_draws == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transfers: %0d seeds, %0d draws; %0d results checked",
             items_sent, seeds_taken, draws_taken, results_checked);
    $display("Output hold-off of %0d cycles %s", HOLD_CYCLES,
             hold_done ? "applied" : "not reached");
    if (fail_count == 0 && pending_draws == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
